### hdl/gcf_pkg.sv
// gcf_pkg: types, constants and arithmetic helpers shared by the contour flattener
// no dependencies; imported by gcf_front, gcf_queue, gcf_back and the top level
package gcf_pkg;

	typedef logic signed [23:0] coord_t;
	typedef logic signed [15:0] pixel_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   on;
	} vertex_t;

	// one walk step handed from front to back: line when ctl is on-curve, else curve
	typedef struct packed {
		vertex_t cur;
		vertex_t ctl;
		vertex_t aft;
		logic    last;
	} task_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCALE,
		F_PLAN,
		F_ISSUE
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WGT,
		B_MUL,
		B_SUM,
		B_EMIT,
		B_FINAL
	} back_state_t;

	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_STEPS = 1'b1;

	localparam logic [23:0] SCALE_RESET = 24'd65536;
	localparam logic [4:0]  STEPS_RESET = 5'd3;

	// a contour end may close two curves, so steps stay within half the result budget
	localparam int STEP_LIMIT = 9;

	localparam logic signed [40:0] SCL_MAX = 41'sd8388607;
	localparam logic signed [40:0] SCL_MIN = -41'sd8388608;
	localparam logic signed [58:0] ACC_MAX = 59'sd8388607;
	localparam logic signed [58:0] ACC_MIN = -59'sd8388608;

	// font units times Q8.16 scale, divided by 256 toward zero, saturated to Q16.8
	function automatic coord_t fix_scale(input logic signed [40:0] p);
		logic signed [40:0] adj;
		logic signed [40:0] sh;
		adj = p + ((p < 0) ? 41'sd255 : 41'sd0);
		sh  = adj >>> 8;
		if (sh > SCL_MAX) fix_scale = 24'sh7FFFFF;
		else if (sh < SCL_MIN) fix_scale = -24'sh800000;
		else fix_scale = sh[23:0];
	endfunction

	// blend sum divided by 2^32 toward zero, saturated to Q16.8
	function automatic coord_t fix_blend(input logic signed [58:0] a);
		logic signed [58:0] adj;
		logic signed [58:0] sh;
		adj = a + ((a < 0) ? 59'sd4294967295 : 59'sd0);
		sh  = adj >>> 32;
		if (sh > ACC_MAX) fix_blend = 24'sh7FFFFF;
		else if (sh < ACC_MIN) fix_blend = -24'sh800000;
		else fix_blend = sh[23:0];
	endfunction

	// Q16.8 to whole pixels toward zero; the Q16.8 range always fits int16
	function automatic pixel_t to_pixel(input coord_t q);
		logic signed [24:0] adj;
		adj = {q[23], q} + ((q < 0) ? 25'sd255 : 25'sd0);
		to_pixel = adj[23:8];
	endfunction

	// floor(s * 65536 / n) for 1 <= s < n <= 9
	function automatic logic [15:0] step_t(input logic [3:0] n, input logic [3:0] s);
		case ({n, s})
			8'h21: step_t = 16'd32768;
			8'h31: step_t = 16'd21845;
			8'h32: step_t = 16'd43690;
			8'h41: step_t = 16'd16384;
			8'h42: step_t = 16'd32768;
			8'h43: step_t = 16'd49152;
			8'h51: step_t = 16'd13107;
			8'h52: step_t = 16'd26214;
			8'h53: step_t = 16'd39321;
			8'h54: step_t = 16'd52428;
			8'h61: step_t = 16'd10922;
			8'h62: step_t = 16'd21845;
			8'h63: step_t = 16'd32768;
			8'h64: step_t = 16'd43690;
			8'h65: step_t = 16'd54613;
			8'h71: step_t = 16'd9362;
			8'h72: step_t = 16'd18724;
			8'h73: step_t = 16'd28086;
			8'h74: step_t = 16'd37449;
			8'h75: step_t = 16'd46811;
			8'h76: step_t = 16'd56173;
			8'h81: step_t = 16'd8192;
			8'h82: step_t = 16'd16384;
			8'h83: step_t = 16'd24576;
			8'h84: step_t = 16'd32768;
			8'h85: step_t = 16'd40960;
			8'h86: step_t = 16'd49152;
			8'h87: step_t = 16'd57344;
			8'h91: step_t = 16'd7281;
			8'h92: step_t = 16'd14563;
			8'h93: step_t = 16'd21845;
			8'h94: step_t = 16'd29127;
			8'h95: step_t = 16'd36408;
			8'h96: step_t = 16'd43690;
			8'h97: step_t = 16'd50972;
			8'h98: step_t = 16'd58254;
			default: step_t = 16'd0;
		endcase
	endfunction

endpackage

### hdl/gcf_front.sv
// gcf_front: accepts contour points, scales them, keeps the contour window and
// head, and issues walk steps (lines and curves) into the task queue; uses gcf_pkg
module gcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic              on_curve,
	input  logic              contour_end,
	input  logic              push,
	output logic              full,
	input  logic [23:0]       scale,
	output gcf_pkg::task_t    task_data,
	output logic              task_push,
	input  logic              task_full
);
	import gcf_pkg::*;

	front_state_t state_q, state_n;

	logic signed [15:0] px_q, py_q;
	logic               on_q, end_q;
	logic signed [40:0] prodx_q, prody_q;

	vertex_t    head_q [2];
	vertex_t    win_q  [3];
	vertex_t    seq_q  [5];
	logic [2:0] emit_q;
	logic [1:0] fill_q, seen_q;
	logic       skip_q;

	vertex_t    v;
	vertex_t    head_n [2];
	vertex_t    win_n  [3];
	vertex_t    seq_n  [5];
	vertex_t    h1e;
	logic [2:0] emit_n;
	logic [1:0] fill_n, seen_n, walk_m;
	logic       sk;
	logic       advance;

	// plan: state update for the new point and which walk steps give lines
	always_comb begin
		v.x = fix_scale(prodx_q);
		v.y = fix_scale(prody_q);
		v.on = on_q;
		head_n = head_q;
		seen_n = seen_q;
		if (seen_q < 2'd2) begin
			if (seen_q == 2'd0) head_n[0] = v;
			else head_n[1] = v;
			seen_n = seen_q + 2'd1;
		end
		win_n = win_q;
		fill_n = fill_q;
		case (fill_q)
			2'd0: begin
				win_n[0] = v;
				fill_n = 2'd1;
			end
			2'd1: begin
				win_n[1] = v;
				fill_n = 2'd2;
			end
			2'd2: begin
				win_n[2] = v;
				fill_n = 2'd3;
			end
			default: begin
				win_n[0] = win_q[1];
				win_n[1] = win_q[2];
				win_n[2] = v;
			end
		endcase
		h1e = (seen_n >= 2'd2) ? head_n[1] : head_n[0];
		seq_n[0] = win_n[0];
		seq_n[1] = win_n[1];
		seq_n[2] = win_n[2];
		seq_n[3] = head_n[0];
		seq_n[4] = h1e;
		if (end_q) begin
			case (fill_n)
				2'd1: begin
					seq_n[1] = head_n[0];
					seq_n[2] = h1e;
				end
				2'd2: begin
					seq_n[2] = head_n[0];
					seq_n[3] = h1e;
				end
				default: ;
			endcase
			walk_m = fill_n;
		end else begin
			walk_m = (fill_n == 2'd3) ? 2'd1 : 2'd0;
		end
		sk = skip_q;
		emit_n = '0;
		for (int j = 0; j < 3; j++) begin
			if (2'(j) < walk_m) begin
				emit_n[j] = !sk && seq_n[j].on;
				sk = sk ? 1'b0 : (seq_n[j].on && !seq_n[j+1].on);
			end
		end
	end

	assign advance = !emit_q[0] || !task_full;

	always_comb begin
		state_n = state_q;
		full = 1'b1;
		task_push = 1'b0;
		task_data.cur = seq_q[0];
		task_data.ctl = seq_q[1];
		task_data.aft = seq_q[2];
		task_data.last = !(emit_q[1] || emit_q[2]);
		case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push) state_n = F_SCALE;
			end
			F_SCALE: state_n = F_PLAN;
			F_PLAN: state_n = F_ISSUE;
			F_ISSUE: begin
				if (emit_q == 3'b000) state_n = F_IDLE;
				else task_push = emit_q[0] && !task_full;
			end
			default: state_n = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q <= '0;
			seen_q <= '0;
			skip_q <= 1'b0;
			emit_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == F_PLAN) begin
				emit_q <= emit_n;
				fill_q <= end_q ? 2'd0 : fill_n;
				seen_q <= end_q ? 2'd0 : seen_n;
				skip_q <= end_q ? 1'b0 : sk;
			end else if (state_q == F_ISSUE && advance) begin
				emit_q <= {1'b0, emit_q[2:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			px_q <= point_x;
			py_q <= point_y;
			on_q <= on_curve;
			end_q <= contour_end;
		end
		if (state_q == F_SCALE) begin
			prodx_q <= px_q * $signed({1'b0, scale});
			prody_q <= py_q * $signed({1'b0, scale});
		end
		if (state_q == F_PLAN) begin
			head_q <= head_n;
			win_q <= win_n;
			seq_q <= seq_n;
		end else if (state_q == F_ISSUE && advance) begin
			for (int i = 0; i < 4; i++) seq_q[i] <= seq_q[i+1];
		end
	end

`ifndef SYNTHESIS
	a_plan_to_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PLAN) |=> (state_q == F_ISSUE))
		else $error("front plan not followed by issue");
	a_busy_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_q != 3'b000) |-> full)
		else $error("front ready with walk steps pending");
`endif

endmodule

### hdl/gcf_queue.sv
// gcf_queue: two-entry task queue between the front and the back of the flattener
// uses gcf_pkg for the task type
module gcf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gcf_pkg::task_t wdata,
	output logic           full,
	input  logic           pop,
	output gcf_pkg::task_t rdata,
	output logic           empty
);
	import gcf_pkg::*;

	task_t      ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wp_q] <= wdata;
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("task pushed into full queue");
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

### hdl/gcf_back.sv
// gcf_back: carries out walk steps, emitting one line per step or flattening a
// quadratic curve step by step into the output register; uses gcf_pkg
module gcf_back #(
	parameter int MAX_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gcf_pkg::task_t    task_data,
	input  logic              task_empty,
	output logic              task_pop,
	input  logic [4:0]        curve_steps,
	output logic signed [15:0] start_x,
	output logic signed [15:0] start_y,
	output logic signed [15:0] end_x,
	output logic signed [15:0] end_y,
	output logic              run_last,
	output logic              empty,
	input  logic              pop
);
	import gcf_pkg::*;

	localparam int StepCap = (MAX_STEPS < STEP_LIMIT) ? MAX_STEPS : STEP_LIMIT;

	back_state_t state_q, state_n;

	task_t              task_q;
	vertex_t            prev_q;
	logic [3:0]         n_q, s_q;
	logic [31:0]        w0_q, w1_q, w2_q;
	logic signed [56:0] mx0_q, mx1_q, mx2_q, my0_q, my1_q, my2_q;
	logic signed [58:0] accx_q, accy_q;
	logic               out_valid_q;
	pixel_t             sx_q, sy_q, ex_q, ey_q;
	logic               last_q;

	logic [3:0]  n_eff;
	logic [15:0] t_w, u_w;
	logic [16:0] u_full;
	coord_t      qx, qy;
	logic        oready;
	logic        out_load;
	pixel_t      sx_n, sy_n, ex_n, ey_n;
	logic        last_n;

	always_comb begin
		if (curve_steps == 5'd0) n_eff = 4'd1;
		else if (curve_steps > 5'(StepCap)) n_eff = 4'(StepCap);
		else n_eff = curve_steps[3:0];
	end

	assign t_w = step_t(n_q, s_q);
	assign u_full = 17'd65536 - {1'b0, t_w};
	assign u_w = u_full[15:0];
	assign qx = fix_blend(accx_q);
	assign qy = fix_blend(accy_q);
	assign oready = !out_valid_q || pop;

	always_comb begin
		state_n = state_q;
		task_pop = 1'b0;
		out_load = 1'b0;
		sx_n = to_pixel(prev_q.x);
		sy_n = to_pixel(prev_q.y);
		ex_n = to_pixel(qx);
		ey_n = to_pixel(qy);
		last_n = 1'b0;
		case (state_q)
			B_IDLE: begin
				sx_n = to_pixel(task_data.cur.x);
				sy_n = to_pixel(task_data.cur.y);
				ex_n = to_pixel(task_data.ctl.x);
				ey_n = to_pixel(task_data.ctl.y);
				last_n = task_data.last;
				if (!task_empty) begin
					if (task_data.ctl.on) begin
						if (oready) begin
							out_load = 1'b1;
							task_pop = 1'b1;
						end
					end else begin
						task_pop = 1'b1;
						state_n = (n_eff == 4'd1) ? B_FINAL : B_WGT;
					end
				end
			end
			B_WGT: state_n = B_MUL;
			B_MUL: state_n = B_SUM;
			B_SUM: state_n = B_EMIT;
			B_EMIT: begin
				if (oready) begin
					out_load = 1'b1;
					state_n = (s_q + 4'd1 == n_q) ? B_FINAL : B_WGT;
				end
			end
			B_FINAL: begin
				ex_n = to_pixel(task_q.aft.x);
				ey_n = to_pixel(task_q.aft.y);
				last_n = task_q.last;
				if (oready) begin
					out_load = 1'b1;
					state_n = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && task_pop) begin
			task_q <= task_data;
			prev_q <= task_data.cur;
			n_q <= n_eff;
			s_q <= 4'd1;
		end
		if (state_q == B_WGT) begin
			w0_q <= {16'd0, u_w} * {16'd0, u_w};
			// u*t never exceeds 2^30, so doubling stays within 32 bits
			w1_q <= ({16'd0, u_w} * {16'd0, t_w}) << 1;
			w2_q <= {16'd0, t_w} * {16'd0, t_w};
		end
		if (state_q == B_MUL) begin
			mx0_q <= $signed({1'b0, w0_q}) * task_q.cur.x;
			mx1_q <= $signed({1'b0, w1_q}) * task_q.ctl.x;
			mx2_q <= $signed({1'b0, w2_q}) * task_q.aft.x;
			my0_q <= $signed({1'b0, w0_q}) * task_q.cur.y;
			my1_q <= $signed({1'b0, w1_q}) * task_q.ctl.y;
			my2_q <= $signed({1'b0, w2_q}) * task_q.aft.y;
		end
		if (state_q == B_SUM) begin
			accx_q <= 59'(mx0_q) + 59'(mx1_q) + 59'(mx2_q);
			accy_q <= 59'(my0_q) + 59'(my1_q) + 59'(my2_q);
		end
		if (state_q == B_EMIT && oready) begin
			prev_q.x <= qx;
			prev_q.y <= qy;
			s_q <= s_q + 4'd1;
		end
		if (out_load) begin
			sx_q <= sx_n;
			sy_q <= sy_n;
			ex_q <= ex_n;
			ey_q <= ey_n;
			last_q <= last_n;
		end
	end

	assign start_x = sx_q;
	assign start_y = sy_q;
	assign end_x = ex_q;
	assign end_y = ey_q;
	assign run_last = last_q;
	assign empty = !out_valid_q;

`ifndef SYNTHESIS
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT && oready) |=> (out_valid_q && !run_last))
		else $error("curve piece not placed in output register");
	a_final_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FINAL && oready) |=> (state_q == B_IDLE && out_valid_q))
		else $error("closing curve piece mishandled");
`endif

endmodule

### hdl/glyph_contour_flattener_unit.sv
// Contour flattener: points go in one per transfer and come out as scaled line
// pieces. For each point the front steps through capture, scale multiply, window
// update and issue check, then issues its planned walk steps in order, up to three
// at a contour end, and holds while the task queue is full. The back emits a
// straight line directly; for a curve it takes the task, runs the weight, blend
// multiply, sum and emit steps of its single blend unit once per interior piece,
// then emits the closing piece; each piece waits for room in the output register.
// A two-entry task queue lets the front take the next point while the back
// still works, and the output register holds a finished line while the back
// continues.
// Depends on gcf_pkg, gcf_front, gcf_queue and gcf_back.
module glyph_contour_flattener_unit #(
	parameter int MAX_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic              on_curve,
	input  logic              contour_end,
	input  logic              push,
	output logic              full,
	output logic signed [15:0] start_x,
	output logic signed [15:0] start_y,
	output logic signed [15:0] end_x,
	output logic signed [15:0] end_y,
	output logic              run_last,
	output logic              empty,
	input  logic              pop
);
	import gcf_pkg::*;

	logic [23:0] scale_q;
	logic [4:0]  steps_q;
	logic        cfg_wr;

	task_t q_wdata, q_rdata;
	logic  q_push, q_full, q_pop, q_empty;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_STEPS) ? {27'd0, steps_q} : {8'd0, scale_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			steps_q <= STEPS_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SCALE) scale_q <= pwdata[23:0];
			else steps_q <= pwdata[4:0];
		end
	end

	gcf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_x     (point_x),
		.point_y     (point_y),
		.on_curve    (on_curve),
		.contour_end (contour_end),
		.push        (push),
		.full        (full),
		.scale       (scale_q),
		.task_data   (q_wdata),
		.task_push   (q_push),
		.task_full   (q_full)
	);

	gcf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	gcf_back #(
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.task_data   (q_rdata),
		.task_empty  (q_empty),
		.task_pop    (q_pop),
		.curve_steps (steps_q),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.run_last    (run_last),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

### sim/gcf_checker.sv
// gcf_checker: predicts the line pieces of the contour flattener and compares each popped line
// watches the point, line and register channels of glyph_contour_flattener_unit; uses gcf_pkg
`timescale 1ns / 100ps

module gcf_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic              on_curve,
	input  logic              contour_end,
	input  logic              push,
	input  logic              full,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic              run_last,
	input  logic              empty,
	input  logic              pop,
	output int                errors,
	output int                pending
);
	import gcf_pkg::*;

	localparam int MAX_STEPS = 16;
	localparam int LINE_CAP  = 18;

	typedef struct {
		longint x;
		longint y;
		bit     on;
	} pt_t;

	typedef struct {
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic               last;
	} line_t;

	line_t  lines_due[$];
	line_t  step_lines[$];
	int     scale_q;
	int     steps_q;
	pt_t    head[2];
	pt_t    win[3];
	int     fill;
	int     seen;
	bit     skip;

	assign pending = lines_due.size();

	function automatic longint sat_q(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic logic signed [15:0] pix(longint q);
		longint v;
		v = q / 256;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	task automatic add_line(longint x1, longint y1, longint x2, longint y2);
		line_t l;
		if (step_lines.size() >= LINE_CAP) return;
		l.sx = pix(x1);
		l.sy = pix(y1);
		l.ex = pix(x2);
		l.ey = pix(y2);
		l.last = 1'b0;
		step_lines.insert(step_lines.size(), l);
	endtask

	task automatic walk(pt_t cur, pt_t ctl, pt_t aft);
		int n;
		longint t, u, w0, w1, w2, px, py, qx, qy;
		if (skip) begin
			skip = 1'b0;
			return;
		end
		if (!cur.on) return;
		if (ctl.on) begin
			add_line(cur.x, cur.y, ctl.x, ctl.y);
			return;
		end
		n = steps_q;
		if (n < 1) n = 1;
		if (n > MAX_STEPS) n = MAX_STEPS;
		if (n > STEP_LIMIT) n = STEP_LIMIT;
		px = cur.x;
		py = cur.y;
		for (int s = 1; s < n; s++) begin
			t = (longint'(s) << 16) / n;
			u = 65536 - t;
			w0 = u * u;
			w1 = 2 * u * t;
			w2 = t * t;
			qx = sat_q((w0 * cur.x + w1 * ctl.x + w2 * aft.x) / 64'sd4294967296);
			qy = sat_q((w0 * cur.y + w1 * ctl.y + w2 * aft.y) / 64'sd4294967296);
			add_line(px, py, qx, qy);
			px = qx;
			py = qy;
		end
		add_line(px, py, aft.x, aft.y);
		skip = 1'b1;
	endtask

	task automatic take_point();
		pt_t v;
		pt_t seq[5];
		int m;
		step_lines.delete();
		v.x = sat_q((longint'(point_x) * scale_q) / 256);
		v.y = sat_q((longint'(point_y) * scale_q) / 256);
		v.on = on_curve;
		if (seen < 2) begin
			head[seen] = v;
			seen++;
		end
		if (fill < 3) begin
			win[fill] = v;
			fill++;
		end else begin
			win[0] = win[1];
			win[1] = win[2];
			win[2] = v;
		end
		if (!contour_end) begin
			if (fill == 3) walk(win[0], win[1], win[2]);
		end else begin
			m = fill;
			for (int j = 0; j < m; j++) seq[j] = win[j];
			seq[m] = head[0];
			seq[m + 1] = (seen >= 2) ? head[1] : head[0];
			for (int j = 0; j < m; j++) walk(seq[j], seq[j + 1], seq[j + 2]);
			fill = 0;
			seen = 0;
			skip = 1'b0;
		end
		if (step_lines.size() > 0) step_lines[step_lines.size() - 1].last = 1'b1;
		lines_due = {lines_due, step_lines};
	endtask

	task automatic report(string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic check_line();
		line_t e;
		if (lines_due.size() == 0) begin
			report($sformatf("line (%0d,%0d)-(%0d,%0d) with none expected",
				start_x, start_y, end_x, end_y));
			return;
		end
		e = lines_due.pop_front();
		if (start_x !== e.sx) report($sformatf("start_x %0d, want %0d", start_x, e.sx));
		if (start_y !== e.sy) report($sformatf("start_y %0d, want %0d", start_y, e.sy));
		if (end_x !== e.ex) report($sformatf("end_x %0d, want %0d", end_x, e.ex));
		if (end_y !== e.ey) report($sformatf("end_y %0d, want %0d", end_y, e.ey));
		if (run_last !== e.last) report($sformatf("run_last %0b, want %0b", run_last, e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q = int'(SCALE_RESET);
			steps_q = int'(STEPS_RESET);
			fill = 0;
			seen = 0;
			skip = 1'b0;
			head[0] = '{0, 0, 1'b0};
			head[1] = '{0, 0, 1'b0};
			foreach (win[i]) win[i] = '{0, 0, 1'b0};
			lines_due.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SCALE) scale_q = int'(pwdata[23:0]);
				else steps_q = int'(pwdata[4:0]);
			end
			if (push && !full) take_point();
			if (pop && !empty) check_line();
		end
	end

endmodule

### sim/tb.sv
// tb: stimulus and verdict for glyph_contour_flattener_unit
// instantiates the block and gcf_checker; uses gcf_pkg for register codes and resets
`timescale 1ns / 100ps

module tb;
	import gcf_pkg::*;

	localparam int SETTLE = 64;
	localparam int STALL_LIMIT = 20000;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic signed [15:0] point_x, point_y;
	logic              on_curve, contour_end, push, full;
	logic signed [15:0] start_x, start_y, end_x, end_y;
	logic              run_last, empty, pop;
	int                errors, pending;
	int                send_idle, recv_stall, quiet;

	glyph_contour_flattener_unit u_top (.*);

	gcf_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stall per cycle
	always @(posedge clk) pop <= ($urandom_range(99) >= recv_stall);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic reg_write(logic idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic on, logic fin);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		point_x <= x;
		point_y <= y;
		on_curve <= on;
		contour_end <= fin;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 16'($urandom_range(4000) - 2000);
		if (r < 85) return 16'($urandom);
		if (r < 93) return 16'sh7FFF;
		return 16'sh8000;
	endfunction

	task automatic rand_contour();
		int len;
		len = $urandom_range(100) < 20 ? $urandom_range(2, 1) : $urandom_range(6, 3);
		for (int i = 0; i < len; i++)
			send(rand_coord(), rand_coord(), $urandom_range(99) < 60, i == len - 1);
	endtask

	initial begin
		logic [23:0] scales[6];
		logic [4:0]  steps[6];
		int sent;
		scales = '{SCALE_RESET, 24'd0, 24'hFFFFFF, 24'd20000, 24'd300000, 24'd65536};
		steps  = '{STEPS_RESET, 5'd0, 5'd31, 5'd9, 5'd16, 5'd1};
		arst_n = 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		point_x <= '0; point_y <= '0; on_curve <= 1'b0; contour_end <= 1'b0;
		push <= 1'b0;
		send_idle = 0;
		recv_stall = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, short contours, curves, extremes
		send(100, 200, 1'b1, 1'b1);
		send(10, 20, 1'b1, 1'b0);
		send(-30, 40, 1'b1, 1'b1);
		send(0, 0, 1'b1, 1'b0);
		send(50, 100, 1'b0, 1'b1);
		send(5, 5, 1'b0, 1'b0);
		send(0, 0, 1'b1, 1'b0);
		send(100, 300, 1'b0, 1'b0);
		send(200, 0, 1'b1, 1'b0);
		send(-100, -100, 1'b0, 1'b1);
		send(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
		send(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		send(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
		send(16'sh8000, 16'sh8000, 1'b1, 1'b1);
		send(16'sh5555, 16'shAAAA, 1'b0, 1'b0);
		send(16'shAAAA, 16'sh5555, 1'b0, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_SCALE, {8'd0, scales[ph]});
			reg_write(REG_STEPS, {27'd0, steps[ph]});
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 86; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 86; end
				default: begin send_idle = 26; recv_stall = 26; end
			endcase
			if (ph == 5) begin
				send_idle = 0;
				recv_stall = 0;
			end
			sent = 0;
			while (sent < 42) begin
				if ($urandom_range(99) < 80) begin
					rand_contour();
					sent += 4;
				end else begin
					// noise: loose points with random flags
					send(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
						1'($urandom_range(1)));
					sent++;
				end
				// sender waits for the block to empty mid-phase
				if (ph == 3 && sent >= 20 && sent < 25) begin
					push <= 1'b0;
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
